FILE: hw/rtl/dhtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhtm_pkg
// shared types and constants of the heartbeat timeout monitor
// ----------------------------------------------------------------------------
package dhtm_pkg;

    // input modes as they arrive in tuser
    localparam logic [1:0] MODE_INIT = 2'd0;
    localparam logic [1:0] MODE_BEAT = 2'd1;
    localparam logic [1:0] MODE_SCAN = 2'd2;

    // status colours
    localparam logic [31:0] RGB_GREEN  = 32'hFF00FF00;
    localparam logic [31:0] RGB_YELLOW = 32'hFFFFFF00;
    localparam logic [31:0] RGB_BLUE   = 32'hFF0000FF;
    localparam logic [31:0] RGB_PINK   = 32'hFFFF00FF;
    localparam logic [31:0] RGB_CYAN   = 32'hFF00FFFF;
    localparam logic [31:0] RGB_RED    = 32'hFFFF0000;
    localparam logic [31:0] RGB_WHITE  = 32'hFFFFFFFF;

    // warning levels with a colour of their own
    localparam logic [2:0] LVL_ONE   = 3'd1;
    localparam logic [2:0] LVL_TWO   = 3'd2;
    localparam logic [2:0] LVL_THREE = 3'd3;
    localparam logic [2:0] LVL_FOUR  = 3'd4;
    localparam logic [2:0] LVL_FIVE  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_AIM     = 2'd0;
    localparam logic [1:0] CFG_REFEREE = 2'd1;
    localparam logic [1:0] CFG_REMOTE  = 2'd2;
    localparam logic [1:0] CFG_VIDEO   = 2'd3;

    localparam int QDEPTH  = 2;
    localparam logic [4:0] CNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        CMD_INIT = 2'd0,
        CMD_BEAT = 2'd1,
        CMD_SCAN = 2'd2
    } cmd_t;

    // one queued command
    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  device;
        logic [31:0] now_ms;
        logic [15:0] timeout_ms;
        logic [2:0]  alert_level;
    } cmd_entry_t;

    // device indexes from the configuration registers
    typedef struct packed {
        logic [3:0] aim;
        logic [3:0] referee;
        logic [3:0] remote;
        logic [3:0] video;
    } cfg_t;

    // scan result, first field in the highest bits
    typedef struct packed {
        logic [1:0]  link_state;
        logic [31:0] status_rgb;
        logic [4:0]  top_level_count;
        logic [2:0]  top_level;
        logic [4:0]  offline_count;
    } result_t;

endpackage

FILE: hw/rtl/dhtm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhtm_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module dhtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/dhtm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhtm_front
// accepts input transactions, classifies them and queues commands
// ----------------------------------------------------------------------------
module dhtm_front #(
    parameter int DEVICES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_mode,
    input  dhtm_pkg::cmd_entry_t in_entry,
    output logic                 q_valid,
    input  logic                 q_pop,
    output dhtm_pkg::cmd_entry_t q_entry
);
    import dhtm_pkg::*;

    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    cmd_entry_t       slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    logic             dev_ok;
    logic             keep;
    logic             push;
    cmd_entry_t       classified;

    assign dev_ok = 32'(in_entry.device) < 32'(DEVICES);

    // unused mode and out of table devices are dropped here
    always_comb begin
        classified = in_entry;
        keep       = 1'b0;
        case (in_mode)
            MODE_INIT: begin
                classified.cmd = CMD_INIT;
                keep           = dev_ok;
            end
            MODE_BEAT: begin
                classified.cmd = CMD_BEAT;
                keep           = dev_ok;
            end
            MODE_SCAN: begin
                classified.cmd = CMD_SCAN;
                keep           = 1'b1;
            end
            default: begin
                classified.cmd = CMD_SCAN;
                keep           = 1'b0;
            end
        endcase
    end

    assign in_ready = count_reg != QCW'(QDEPTH);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = count_reg != '0;
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

FILE: hw/rtl/dhtm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhtm_back
// executes queued commands on the device table and produces scan results
// ----------------------------------------------------------------------------
module dhtm_back #(
    parameter int DEVICES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dhtm_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  dhtm_pkg::cmd_entry_t q_entry,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dhtm_pkg::result_t    out_result
);
    import dhtm_pkg::*;

    localparam int AW  = $clog2(DEVICES);
    localparam int PAD = (DEVICES > 16) ? DEVICES : 16;
    localparam int PAW = $clog2(PAD);
    localparam int TLW = 16 + 3;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [31:0]       now_reg;
    logic              chk_vld_reg;
    logic [AW-1:0]     chk_idx_reg;
    logic              lsv_q_reg, tlv_q_reg;
    logic [DEVICES-1:0] ls_vld_reg, tl_vld_reg, online_reg;
    logic [4:0]        off_cnt_reg, top_cnt_reg;
    logic [2:0]        top_reg;
    logic              out_valid_reg;
    result_t           out_result_reg;

    logic [PAW-1:0]    dev_ext;
    logic [AW-1:0]     wr_addr;
    logic              ls_we, tl_we;
    logic [31:0]       ls_q;
    logic [TLW-1:0]    tl_q;
    logic [31:0]       seen;
    logic [15:0]       tmo;
    logic [2:0]        lvl;
    logic [31:0]       age;
    logic              is_off;
    logic [PAD-1:0]    on_pad;
    logic              aim_on, ref_on, rem_on, vid_on;
    logic              out_load;
    result_t           res;

    assign dev_ext = PAW'(q_entry.device);
    assign wr_addr = dev_ext[AW-1:0];
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign ls_we   = q_pop && (q_entry.cmd == CMD_INIT || q_entry.cmd == CMD_BEAT);
    assign tl_we   = q_pop && (q_entry.cmd == CMD_INIT);

    dhtm_ram #(.WIDTH(32), .DEPTH(DEVICES)) u_seen_ram (
        .aclk    (aclk),
        .wr_en   (ls_we),
        .wr_addr (wr_addr),
        .wr_data (q_entry.now_ms),
        .rd_addr (idx_reg),
        .rd_data (ls_q)
    );

    dhtm_ram #(.WIDTH(TLW), .DEPTH(DEVICES)) u_limit_ram (
        .aclk    (aclk),
        .wr_en   (tl_we),
        .wr_addr (wr_addr),
        .wr_data ({q_entry.timeout_ms, q_entry.alert_level}),
        .rd_addr (idx_reg),
        .rd_data (tl_q)
    );

    // entries never written read as zero
    assign seen   = lsv_q_reg ? ls_q : '0;
    assign tmo    = tlv_q_reg ? tl_q[TLW-1:3] : '0;
    assign lvl    = tlv_q_reg ? tl_q[2:0] : '0;
    assign age    = now_reg - seen;
    assign is_off = age > {16'd0, tmo};

    // indexes beyond the table see zero, i.e. offline
    assign on_pad = PAD'(online_reg);
    assign aim_on = on_pad[PAW'(cfg.aim)];
    assign ref_on = on_pad[PAW'(cfg.referee)];
    assign rem_on = on_pad[PAW'(cfg.remote)];
    assign vid_on = on_pad[PAW'(cfg.video)];

    always_comb begin
        res                 = '0;
        res.offline_count   = off_cnt_reg;
        res.top_level       = top_reg;
        res.top_level_count = top_cnt_reg;
        res.link_state      = {vid_on, rem_on};
        res.status_rgb      = RGB_GREEN;
        if (off_cnt_reg != '0) begin
            case (top_reg)
                LVL_ONE:   res.status_rgb = (!aim_on && !ref_on) ? RGB_YELLOW : RGB_GREEN;
                LVL_TWO:   res.status_rgb = RGB_BLUE;
                LVL_THREE: res.status_rgb = RGB_PINK;
                LVL_FOUR:  res.status_rgb = RGB_CYAN;
                LVL_FIVE:  res.status_rgb = RGB_RED;
                default:   res.status_rgb = RGB_WHITE;
            endcase
        end
    end

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (q_pop && q_entry.cmd == CMD_SCAN) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == AW'(DEVICES - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            ls_vld_reg    <= '0;
            tl_vld_reg    <= '0;
            online_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= (state_reg == ST_SCAN);
            if (ls_we) begin
                ls_vld_reg[wr_addr] <= 1'b1;
            end
            if (tl_we) begin
                tl_vld_reg[wr_addr] <= 1'b1;
                online_reg[wr_addr] <= 1'b0;
            end
            if (chk_vld_reg) begin
                online_reg[chk_idx_reg] <= !is_off;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        lsv_q_reg   <= ls_vld_reg[idx_reg];
        tlv_q_reg   <= tl_vld_reg[idx_reg];
        chk_idx_reg <= idx_reg;
        if (q_pop && q_entry.cmd == CMD_SCAN) begin
            now_reg     <= q_entry.now_ms;
            off_cnt_reg <= '0;
            top_reg     <= '0;
            top_cnt_reg <= '0;
        end else if (chk_vld_reg && is_off) begin
            if (off_cnt_reg != CNT_MAX) begin
                off_cnt_reg <= off_cnt_reg + 1'b1;
            end
            if (lvl > top_reg) begin
                top_reg     <= lvl;
                top_cnt_reg <= 5'd1;
            end else if (lvl == top_reg && top_cnt_reg != CNT_MAX) begin
                top_cnt_reg <= top_cnt_reg + 1'b1;
            end
        end
        if (out_load) begin
            out_result_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

FILE: hw/rtl/device_heartbeat_timeout_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_heartbeat_timeout_monitor_top
// heartbeat timeout monitor over a table of devices with scan reporting
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  tuser mode, tdata device..level
//  m_        out        m_tvalid/m_tready  tdata scan report
//  cfg_      in         cfg_wr_en          cfg_addr, cfg_wdata
//
//  an init or heartbeat is written to the table as it is popped; a scan walks
//  through the table ram, one entry per cycle
//  the front queue holds two commands, so up to two can queue during a scan
//  reset clears control state and the per-entry valid bits; no clearing pass
//  a held result stalls the end of the next scan, and with it all later inits and heartbeats
// ----------------------------------------------------------------------------
module device_heartbeat_timeout_monitor_top #(
    parameter int DEVICES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [3:0]  cfg_wdata,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // device[3:0], now_ms[35:4], timeout_ms[51:36],
                                   // alert_level[54:52], zero fill
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // offline_count[4:0], top_level[7:5],
                                   // top_level_count[12:8], status_rgb[44:13],
                                   // link_state[46:45], zero fill
);
    import dhtm_pkg::*;

    cfg_t       cfg_reg;
    cmd_entry_t in_entry;
    cmd_entry_t q_entry;
    logic       q_valid, q_pop;
    result_t    result;

    // the user must write register indexes only while the block is idle; the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.aim     <= 4'd0;
            cfg_reg.referee <= 4'd1;
            cfg_reg.remote  <= 4'd2;
            cfg_reg.video   <= 4'd3;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_AIM:     cfg_reg.aim     <= cfg_wdata;
                CFG_REFEREE: cfg_reg.referee <= cfg_wdata;
                CFG_REMOTE:  cfg_reg.remote  <= cfg_wdata;
                CFG_VIDEO:   cfg_reg.video   <= cfg_wdata;
                default:     cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // unpack the input transaction; cmd is set by the front end
    always_comb begin
        in_entry             = '0;
        in_entry.device      = s_tdata[3:0];
        in_entry.now_ms      = s_tdata[35:4];
        in_entry.timeout_ms  = s_tdata[51:36];
        in_entry.alert_level = s_tdata[54:52];
    end

    dhtm_front #(.DEVICES(DEVICES)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_entry (in_entry),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_entry  (q_entry)
    );

    dhtm_back #(.DEVICES(DEVICES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_entry    (q_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // one zero bit fills the report up to six bytes
    assign m_tdata = {1'b0, result};

endmodule
